// ----- design/mvyr_pkg.sv -----
// Package for the movement vector yaw rotator: types, widths and the arctangent table.
package mvyr_pkg;

    localparam int ANGLE_BITS = 16;
    localparam int MOVE_BITS  = 16;
    localparam int TURN_BITS  = 32;
    localparam int FRAC_BITS  = 16;
    localparam int GAIN_BITS  = 31;
    localparam int PROD_W     = MOVE_BITS + GAIN_BITS;
    localparam int PRE_SHIFT  = 30 - FRAC_BITS;
    localparam int XW         = 35;
    localparam int ZW         = 34;
    localparam int TABLE_LEN  = 32;

    localparam logic signed [GAIN_BITS-1:0] INV_GAIN_Q30 = 31'sd652032874;

    localparam logic [TURN_BITS-1:0] QUARTER_TURN       = 32'h4000_0000;
    localparam logic [TURN_BITS-1:0] HALF_TURN          = 32'h8000_0000;
    localparam logic [TURN_BITS-1:0] THREE_QUARTER_TURN = 32'hC000_0000;

    localparam logic [TURN_BITS-1:0] ATAN_TABLE [TABLE_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef struct packed {
        logic signed [MOVE_BITS-1:0] forward_move;
        logic signed [MOVE_BITS-1:0] side_move;
        logic [ANGLE_BITS-1:0]       current_pitch;
        logic [ANGLE_BITS-1:0]       current_yaw;
        logic [ANGLE_BITS-1:0]       target_pitch;
        logic [ANGLE_BITS-1:0]       target_yaw;
    } move_in_t;

    typedef struct packed {
        logic signed [MOVE_BITS-1:0] new_forward_move;
        logic signed [MOVE_BITS-1:0] new_side_move;
    } move_out_t;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } rot_t;

endpackage

// ----- design/mvyr_prep.sv -----
// Front end: gain-compensating multiply, view yaw difference and quadrant fold.
module mvyr_prep (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  mvyr_pkg::move_in_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output mvyr_pkg::rot_t    out_data
);
    import mvyr_pkg::*;

    logic                    s1_valid_reg;
    logic                    s1_valid_next;
    logic signed [PROD_W-1:0] pf_reg;
    logic signed [PROD_W-1:0] ps_reg;
    logic                    flip_reg;
    logic signed [ZW-1:0]    z_reg;
    logic                    s2_valid_reg;
    logic                    s2_valid_next;
    logic                    s2_ready;
    rot_t                    rot_reg;
    rot_t                    rot_next;

    logic [TURN_BITS-1:0]     cur_p;
    logic [TURN_BITS-1:0]     cur_y;
    logic [TURN_BITS-1:0]     tgt_p;
    logic [TURN_BITS-1:0]     tgt_y;
    logic [TURN_BITS-1:0]     d;
    logic [TURN_BITS-1:0]     d_fold;
    logic [TURN_BITS-1:0]     d_quad;
    logic                     flip;
    logic signed [PROD_W-1:0] pf;
    logic signed [PROD_W-1:0] ps;
    logic signed [PROD_W-1:0] pf_sh;
    logic signed [PROD_W-1:0] ps_sh;
    logic signed [XW-1:0]     xf;
    logic signed [XW-1:0]     ys;

    always_comb
    begin
        cur_p = {in_data.current_pitch, {(TURN_BITS-ANGLE_BITS){1'b0}}};
        cur_y = {in_data.current_yaw,   {(TURN_BITS-ANGLE_BITS){1'b0}}};
        tgt_p = {in_data.target_pitch,  {(TURN_BITS-ANGLE_BITS){1'b0}}};
        tgt_y = {in_data.target_yaw,    {(TURN_BITS-ANGLE_BITS){1'b0}}};
        if (cur_p > QUARTER_TURN && cur_p < THREE_QUARTER_TURN)
        begin
            cur_y = cur_y + HALF_TURN;
        end
        if (tgt_p > QUARTER_TURN && tgt_p < THREE_QUARTER_TURN)
        begin
            tgt_y = tgt_y + HALF_TURN;
        end
        d      = tgt_y - cur_y;
        d_quad = d + QUARTER_TURN;
        flip   = d_quad[TURN_BITS-1];
        d_fold = flip ? d + HALF_TURN : d;
        pf = PROD_W'(in_data.forward_move) * PROD_W'(INV_GAIN_Q30);
        ps = PROD_W'(in_data.side_move) * PROD_W'(INV_GAIN_Q30);
    end

    always_comb
    begin
        pf_sh = pf_reg >>> PRE_SHIFT;
        ps_sh = ps_reg >>> PRE_SHIFT;
        xf    = pf_sh[XW-1:0];
        ys    = ps_sh[XW-1:0];
        rot_next.x = flip_reg ? -xf : xf;
        rot_next.y = flip_reg ? -ys : ys;
        rot_next.z = z_reg;
    end

    assign s2_ready      = !s2_valid_reg || out_ready;
    assign in_ready      = !s1_valid_reg || s2_ready;
    assign s1_valid_next = in_ready ? in_valid : s1_valid_reg;
    assign s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            pf_reg   <= pf;
            ps_reg   <= ps;
            flip_reg <= flip;
            z_reg    <= $signed({{(ZW-TURN_BITS){d_fold[TURN_BITS-1]}}, d_fold});
        end
        if (s1_valid_reg && s2_ready)
        begin
            rot_reg <= rot_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_data  = rot_reg;

endmodule

// ----- design/mvyr_cell.sv -----
// One CORDIC rotation cell: a micro-rotation by the table angle of its stage.
module mvyr_cell #(
    parameter int STAGE = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  mvyr_pkg::rot_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output mvyr_pkg::rot_t out_data
);
    import mvyr_pkg::*;

    logic                 valid_reg;
    logic                 valid_next;
    rot_t                 data_reg;
    rot_t                 data_next;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic signed [ZW-1:0] step;

    always_comb
    begin
        xs   = in_data.x >>> STAGE;
        ys   = in_data.y >>> STAGE;
        step = $signed({{(ZW-TURN_BITS){1'b0}}, ATAN_TABLE[STAGE]});
        if (!in_data.z[ZW-1])
        begin
            data_next.x = in_data.x - ys;
            data_next.y = in_data.y + xs;
            data_next.z = in_data.z - step;
        end
        else
        begin
            data_next.x = in_data.x + ys;
            data_next.y = in_data.y - xs;
            data_next.z = in_data.z + step;
        end
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- design/mvyr_finish.sv -----
// Back end: round off the fraction, saturate and hold the result in the output register.
module mvyr_finish (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  mvyr_pkg::rot_t     in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output mvyr_pkg::move_out_t out_data
);
    import mvyr_pkg::*;

    localparam logic signed [XW-1:0] ROUND_HALF =
        $signed({{(XW-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}});

    logic                 valid_reg;
    logic                 valid_next;
    move_out_t            data_reg;
    move_out_t            data_next;
    logic signed [XW-1:0] rx;
    logic signed [XW-1:0] ry;

    function automatic logic signed [MOVE_BITS-1:0] clamp(input logic signed [XW-1:0] v);
        logic signed [MOVE_BITS-1:0] r;
        if (v[XW-1:MOVE_BITS-1] == {(XW-MOVE_BITS+1){1'b0}} ||
            v[XW-1:MOVE_BITS-1] == {(XW-MOVE_BITS+1){1'b1}})
        begin
            r = v[MOVE_BITS-1:0];
        end
        else if (v[XW-1])
        begin
            r = $signed({1'b1, {(MOVE_BITS-1){1'b0}}});
        end
        else
        begin
            r = $signed({1'b0, {(MOVE_BITS-1){1'b1}}});
        end
        return r;
    endfunction

    always_comb
    begin
        rx = (in_data.x + ROUND_HALF) >>> FRAC_BITS;
        ry = (in_data.y + ROUND_HALF) >>> FRAC_BITS;
        data_next.new_forward_move = clamp(rx);
        data_next.new_side_move    = clamp(ry);
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- design/move_vector_yaw_rotation_top.sv -----
// Top level of the movement vector yaw rotator: front end, CORDIC cell chain, output stage.
//
// Usage:
//   move channel (move_valid / move_ready / move) carries one movement vector and
//   the current and target view (pitch, yaw in binary angle units) per transaction.
//   result channel (result_valid / result_ready / result) returns the vector rotated
//   by the yaw difference, Q16.0, saturated; exactly one result per transaction.
//   Path: the move is accepted into the multiply register, which also takes the folded
//   yaw difference; then the rotation input register, one register per CORDIC cell
//   and one output register lead to result_valid.
//   Throughput: one transaction per cycle while result_ready stays high; each cell holds one transaction.
//   Stall: every stage has its own valid register and accepts while its successor
//   takes or it is empty, so bubbles collapse; with result_ready low the chain
//   fills and move_ready drops once all ROTATION_STAGES + 3 stages hold data.
//   Reset: rst_n clears all valid bits; no transaction is in flight afterwards.
module move_vector_yaw_rotation_top #(
    parameter int ROTATION_STAGES = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                move_valid,
    output logic                move_ready,
    input  mvyr_pkg::move_in_t  move,
    output logic                result_valid,
    input  logic                result_ready,
    output mvyr_pkg::move_out_t result
);
    import mvyr_pkg::*;

    localparam int NUM_CELLS = (ROTATION_STAGES > TABLE_LEN) ? TABLE_LEN : ROTATION_STAGES;
    localparam int DEPTH     = NUM_CELLS + 3;
    localparam int CNT_W     = $clog2(DEPTH + 1);

    rot_t cell_data  [NUM_CELLS+1];
    logic cell_valid [NUM_CELLS+1];
    logic cell_ready [NUM_CELLS+1];

    logic [CNT_W-1:0] inflight_reg;
    logic [CNT_W-1:0] inflight_next;

    mvyr_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (move_valid),
        .in_ready  (move_ready),
        .in_data   (move),
        .out_valid (cell_valid[0]),
        .out_ready (cell_ready[0]),
        .out_data  (cell_data[0])
    );

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        mvyr_cell #(
            .STAGE (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (cell_valid[i]),
            .in_ready  (cell_ready[i]),
            .in_data   (cell_data[i]),
            .out_valid (cell_valid[i+1]),
            .out_ready (cell_ready[i+1]),
            .out_data  (cell_data[i+1])
        );
    end

    mvyr_finish u_finish (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cell_valid[NUM_CELLS]),
        .in_ready  (cell_ready[NUM_CELLS]),
        .in_data   (cell_data[NUM_CELLS]),
        .out_valid (result_valid),
        .out_ready (result_ready),
        .out_data  (result)
    );

    // transactions in flight, for checking only
    always_comb
    begin
        inflight_next = inflight_reg;
        if (move_valid && move_ready && !(result_valid && result_ready))
        begin
            inflight_next = inflight_reg + CNT_W'(1);
        end
        else if (!(move_valid && move_ready) && result_valid && result_ready)
        begin
            inflight_next = inflight_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> move_ready)
        else $error("move_ready low while the output stage is empty");

    a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> inflight_reg != '0)
        else $error("result presented with no transaction in flight");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= CNT_W'(DEPTH))
        else $error("more transactions in flight than pipeline stages");

    a_full_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
        (inflight_reg == CNT_W'(DEPTH) && !result_ready) |-> !move_ready)
        else $error("input accepted while the pipeline is full and stalled");

endmodule

// ----- dv/tb.sv -----
// Testbench for the movement vector yaw rotator: random and directed moves checked against a predictor.
`timescale 1ns / 100ps

module tb;
    import mvyr_pkg::*;

    localparam int STAGES       = 16;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = STAGES + 8;
    localparam int PHASE_ITEMS  = 300;
    localparam int MAX_PRINTS   = 20;

    localparam logic [ANGLE_BITS-1:0] QUARTER = QUARTER_TURN[TURN_BITS-1 -: ANGLE_BITS];
    localparam logic [ANGLE_BITS-1:0] HALF    = HALF_TURN[TURN_BITS-1 -: ANGLE_BITS];
    localparam logic [ANGLE_BITS-1:0] THREE_Q = THREE_QUARTER_TURN[TURN_BITS-1 -: ANGLE_BITS];
    localparam logic signed [MOVE_BITS-1:0] MOVE_MAX = {1'b0, {(MOVE_BITS-1){1'b1}}};
    localparam logic signed [MOVE_BITS-1:0] MOVE_MIN = {1'b1, {(MOVE_BITS-1){1'b0}}};

    class move_scoreboard;
        move_out_t expected_q[$];
        int        errors;
        int        checked;
        int        saturated;

        function logic [TURN_BITS-1:0] view_heading(logic [ANGLE_BITS-1:0] pitch,
                                                     logic [ANGLE_BITS-1:0] yaw);
            logic [TURN_BITS-1:0] p;
            logic [TURN_BITS-1:0] h;
            p = {pitch, {(TURN_BITS-ANGLE_BITS){1'b0}}};
            h = {yaw, {(TURN_BITS-ANGLE_BITS){1'b0}}};
            if (p > QUARTER_TURN && p < THREE_QUARTER_TURN)
                h = h + HALF_TURN;
            return h;
        endfunction

        function logic signed [MOVE_BITS-1:0] round_clamp(longint v);
            longint r;
            r = (v + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
            if (r > longint'(MOVE_MAX))
            begin
                r = longint'(MOVE_MAX);
                saturated++;
            end
            else if (r < longint'(MOVE_MIN))
            begin
                r = longint'(MOVE_MIN);
                saturated++;
            end
            return r[MOVE_BITS-1:0];
        endfunction

        function move_out_t rotate_move(move_in_t m);
            longint               x;
            longint               y;
            longint               z;
            longint               xs;
            longint               ys;
            logic [TURN_BITS-1:0] d;
            move_out_t            r;
            d = view_heading(m.target_pitch, m.target_yaw)
                - view_heading(m.current_pitch, m.current_yaw);
            x = (longint'($signed(m.forward_move)) * longint'(INV_GAIN_Q30)) >>> PRE_SHIFT;
            y = (longint'($signed(m.side_move)) * longint'(INV_GAIN_Q30)) >>> PRE_SHIFT;
            if (((d + QUARTER_TURN) & HALF_TURN) != '0)
            begin
                x = -x;
                y = -y;
                d = d + HALF_TURN;
            end
            z = longint'($signed(d));
            for (int i = 0; i < STAGES && i < TABLE_LEN; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0)
                begin
                    x = x - ys;
                    y = y + xs;
                    z = z - longint'(ATAN_TABLE[i]);
                end
                else
                begin
                    x = x + ys;
                    y = y - xs;
                    z = z + longint'(ATAN_TABLE[i]);
                end
            end
            r.new_forward_move = round_clamp(x);
            r.new_side_move    = round_clamp(y);
            return r;
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTS)
                $display("ERROR @%0t: %s", $realtime, msg);
            errors++;
        endtask

        function void note_move(move_in_t m);
            expected_q.push_back(rotate_move(m));
        endfunction

        task check_result(move_out_t got);
            move_out_t want;
            if (expected_q.size() == 0)
            begin
                report("result transaction with nothing pending");
            end
            else
            begin
                want = expected_q.pop_front();
                checked++;
                if (got.new_forward_move !== want.new_forward_move)
                    report($sformatf("new_forward_move got %0d expected %0d",
                                     got.new_forward_move, want.new_forward_move));
                if (got.new_side_move !== want.new_side_move)
                    report($sformatf("new_side_move got %0d expected %0d",
                                     got.new_side_move, want.new_side_move));
            end
        endtask
    endclass

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      move_valid   = 1'b0;
    logic      move_ready;
    move_in_t  move         = '0;
    logic      result_valid;
    logic      result_ready = 1'b0;
    move_out_t result;

    int             send_idle_pct = 0;
    int             recv_idle_pct = 0;
    int             stall_cycles  = 0;
    int             sent          = 0;
    move_scoreboard sb            = new();

    move_vector_yaw_rotation_top #(
        .ROTATION_STAGES(STAGES)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .move_valid  (move_valid),
        .move_ready  (move_ready),
        .move        (move),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && move_valid && move_ready)
            sb.note_move(move);
        if (rst_n && result_valid && result_ready)
            sb.check_result(result);
    end

    always @(posedge clk)
        result_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (!rst_n || (move_valid && move_ready) || (result_valid && result_ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("no transaction for %0d cycles, %0d results pending",
                     STALL_LIMIT, sb.expected_q.size());
            $display("tb failed");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic move_in_t make_move(logic [MOVE_BITS-1:0] fwd, logic [MOVE_BITS-1:0] side,
                                           logic [ANGLE_BITS-1:0] cp, logic [ANGLE_BITS-1:0] cy,
                                           logic [ANGLE_BITS-1:0] tp, logic [ANGLE_BITS-1:0] ty);
        move_in_t m;
        m.forward_move  = fwd;
        m.side_move     = side;
        m.current_pitch = cp;
        m.current_yaw   = cy;
        m.target_pitch  = tp;
        m.target_yaw    = ty;
        return m;
    endfunction

    function automatic logic [ANGLE_BITS-1:0] near_boundary();
        logic [ANGLE_BITS-1:0] base;
        case ($urandom_range(3))
            0: base = '0;
            1: base = QUARTER;
            2: base = HALF;
            default: base = THREE_Q;
        endcase
        return base + ANGLE_BITS'($urandom_range(4)) - ANGLE_BITS'(2);
    endfunction

    function automatic logic [MOVE_BITS-1:0] random_component(int kind);
        case (kind)
            0: return MOVE_BITS'($urandom);
            1: return $urandom_range(1) ? MOVE_MAX : MOVE_MIN;
            default: return MOVE_BITS'($urandom_range(512)) - MOVE_BITS'(256);
        endcase
    endfunction

    function automatic move_in_t random_move();
        move_in_t m;
        int       mk;
        mk = $urandom_range(9);
        m.forward_move  = random_component(mk < 6 ? 0 : mk - 6);
        m.side_move     = random_component(mk < 6 ? 0 : mk - 6);
        m.current_pitch = ANGLE_BITS'($urandom);
        m.current_yaw   = ANGLE_BITS'($urandom);
        m.target_pitch  = ANGLE_BITS'($urandom);
        m.target_yaw    = ANGLE_BITS'($urandom);
        case ($urandom_range(5))
            0:
            begin
                m.current_pitch = near_boundary();
                m.target_pitch  = near_boundary();
            end
            1: m.target_yaw = m.current_yaw + near_boundary();
            2:
            begin
                m.forward_move = '0;
                m.side_move    = '0;
            end
            default: ;
        endcase
        return m;
    endfunction

    task send_move(move_in_t m);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            move_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        move       <= m;
        move_valid <= 1'b1;
        do
            @(posedge clk);
        while (!move_ready);
        sent++;
    endtask

    task send_directed();
        move_in_t list[$];
        list.push_back(make_move('0, '0, 16'h1234, 16'h5678, 16'h9abc, 16'hdef0));
        list.push_back(make_move(MOVE_MAX, '0, '0, '0, '0, '0));
        list.push_back(make_move(MOVE_MIN, MOVE_MIN, '0, '0, '0, '0));
        list.push_back(make_move(MOVE_MAX, MOVE_MAX, '0, '0, '0, 16'h2000));
        list.push_back(make_move(MOVE_MIN, MOVE_MIN, '0, '0, '0, 16'h2000));
        list.push_back(make_move(MOVE_MIN, MOVE_MAX, '0, 16'h6000, '0, '0));
        list.push_back(make_move(16'sd160, -16'sd48, '0, '0, '0, QUARTER));
        list.push_back(make_move(16'sd160, -16'sd48, '0, '0, '0, HALF));
        list.push_back(make_move(16'sd160, -16'sd48, '0, '0, '0, THREE_Q));
        list.push_back(make_move(16'sd160, -16'sd48, '0, '0, '0, QUARTER - 1'b1));
        list.push_back(make_move(16'sd160, -16'sd48, '0, '0, '0, THREE_Q - 1'b1));
        list.push_back(make_move(16'sd160, -16'sd48, '0, '0, '0, 16'hffff));
        list.push_back(make_move(16'sd999, 16'sd777, QUARTER, 16'h0100, '0, 16'h0100));
        list.push_back(make_move(16'sd999, 16'sd777, QUARTER + 1'b1, 16'h0100, '0, 16'h0100));
        list.push_back(make_move(16'sd999, 16'sd777, HALF, 16'h0100, '0, 16'h0100));
        list.push_back(make_move(16'sd999, 16'sd777, THREE_Q, 16'h0100, '0, 16'h0100));
        list.push_back(make_move(16'sd999, 16'sd777, THREE_Q - 1'b1, 16'h0100, '0, 16'h0100));
        list.push_back(make_move(16'sd999, 16'sd777, '0, 16'h0100, HALF, 16'h0100));
        list.push_back(make_move(16'sd999, 16'sd777, HALF, 16'h0100, HALF, 16'h0100));
        list.push_back(make_move(16'sd1, -16'sd1, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
        list.push_back(make_move(-16'sd1, 16'sd1, 16'h7fff, 16'h8000, 16'h8001, 16'h7fff));
        list.push_back(make_move(16'h5555, 16'haaaa, 16'haaaa, 16'h5555, 16'h5555, 16'haaaa));
        foreach (list[i])
            send_move(list[i]);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 23;
                    recv_idle_pct = 74;
                end
                1:
                begin
                    send_idle_pct = 74;
                    recv_idle_pct = 23;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (phase == 0)
                send_directed();
            repeat (PHASE_ITEMS) send_move(random_move());
        end
        move_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("%0d move transactions under three idle mixes, %0d results compared",
                 sent, sb.checked);
        $display("%0d predicted components saturated, %0d mismatches", sb.saturated, sb.errors);
        if (sb.errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

// ----- files.f -----
design/mvyr_pkg.sv
design/mvyr_prep.sv
design/mvyr_cell.sv
design/mvyr_finish.sv
design/move_vector_yaw_rotation_top.sv
dv/tb.sv
